[design/sset_pkg.sv]
package sset_pkg;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF     = 64;
    localparam int KEY_BYTES_DEF = 8;

    // Fixed port widths
    localparam int FUNC_W = 2;
    localparam int KEY_W  = 64;
    localparam int CAP_W  = 7;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes; find is code 2, and the unused code 3 also acts as find
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic load;       // take the input beat, start a search
        logic probe;      // read the entry at mid
        logic narrow;     // move lo or hi from the probed entry
        logic hit_probe;  // read the entry at lo
        logic hit_check;  // compare the entry at lo with the key
        logic init_up;    // idx <= count, start shifting up
        logic init_dn;    // idx <= lo, start shifting down
        logic shrd_up;    // read idx-1
        logic shwr_up;    // write idx, step down
        logic shrd_dn;    // read idx+1
        logic shwr_dn;    // write idx, step up
        logic ins;        // write key at lo, count up
        logic del;        // count down
        logic set_full;   // flag a refused add
        logic out_load;   // move the result into the output register
    } cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic lo_lt_hi;
        logic lo_lt_count;
        logic add_ok;
        logic add_full;
        logic rem_ok;
        logic up_more;
        logic dn_more;
        logic out_busy;
    } sts_t;

endpackage

[design/sset_ram.sv]
module sset_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/sset_ctrl.sv]
module sset_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  sset_pkg::sts_t sts,
    output sset_pkg::cmd_t cmd
);
    import sset_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROBE  = 4'd1;
    localparam logic [3:0] S_NARROW = 4'd2;
    localparam logic [3:0] S_HITCHK = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_UPRD   = 4'd5;
    localparam logic [3:0] S_UPWR   = 4'd6;
    localparam logic [3:0] S_DNRD   = 4'd7;
    localparam logic [3:0] S_DNWR   = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (sts.lo_lt_hi)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_NARROW;
                end
                else if (sts.lo_lt_count)
                begin
                    cmd.hit_probe = 1'b1;
                    state_next    = S_HITCHK;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_NARROW:
            begin
                cmd.narrow = 1'b1;
                state_next = S_PROBE;
            end
            S_HITCHK:
            begin
                cmd.hit_check = 1'b1;
                state_next    = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.add_ok)
                begin
                    cmd.init_up = 1'b1;
                    state_next  = S_UPRD;
                end
                else if (sts.rem_ok)
                begin
                    cmd.init_dn = 1'b1;
                    state_next  = S_DNRD;
                end
                else
                begin
                    cmd.set_full = sts.add_full;
                    state_next   = S_DONE;
                end
            end
            S_UPRD:
            begin
                if (sts.up_more)
                begin
                    cmd.shrd_up = 1'b1;
                    state_next  = S_UPWR;
                end
                else
                begin
                    cmd.ins    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_UPWR:
            begin
                cmd.shwr_up = 1'b1;
                state_next  = S_UPRD;
            end
            S_DNRD:
            begin
                if (sts.dn_more)
                begin
                    cmd.shrd_dn = 1'b1;
                    state_next  = S_DNWR;
                end
                else
                begin
                    cmd.del    = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DNWR:
            begin
                cmd.shwr_dn = 1'b1;
                state_next  = S_DNRD;
            end
            S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/sset_dpath.sv]
module sset_dpath #(
    parameter int DEPTH     = 64,
    parameter int KEY_BYTES = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sset_pkg::cmd_t                    cmd,
    output sset_pkg::sts_t                    sts,
    input  logic [sset_pkg::FUNC_W-1:0]       func,
    input  logic [sset_pkg::KEY_W-1:0]        key,
    input  logic                              cfg_valid,
    input  logic [sset_pkg::CAP_W-1:0]        capacity,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [$clog2(DEPTH+1)-1:0]        position,
    output logic [$clog2(DEPTH+1)-1:0]        entry_total,
    output logic                              status
);
    import sset_pkg::*;

    localparam int KW = 8 * KEY_BYTES;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    logic [FUNC_W-1:0] func_reg;
    logic [KW-1:0]     key_reg;
    logic [CW-1:0]     lo_reg;
    logic [CW-1:0]     hi_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;
    logic              hit_reg;
    logic              full_reg;
    logic [CAP_W-1:0]  capacity_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic [CW-1:0]     position_reg;
    logic [CW-1:0]     total_reg;
    logic              status_reg;

    logic [CW-1:0] mid;
    logic [CW-1:0] rd_idx;
    logic          room;
    logic          is_add;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;

    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign is_add = (func_reg == FUNC_ADD);
    // below both the written capacity and the storage depth
    assign room   = (LW'(count_reg) < LW'(capacity_reg)) && (count_reg < CW'(DEPTH));

    assign sts.lo_lt_hi    = (lo_reg < hi_reg);
    assign sts.lo_lt_count = (lo_reg < count_reg);
    assign sts.add_ok      = is_add && !hit_reg && room;
    assign sts.add_full    = is_add && !hit_reg && !room;
    assign sts.rem_ok      = (func_reg == FUNC_REMOVE) && hit_reg;
    assign sts.up_more     = (idx_reg > lo_reg);
    assign sts.dn_more     = ((idx_reg + 1'b1) < count_reg);
    assign sts.out_busy    = out_valid_reg && out_stall;

    always_comb
    begin
        rd_idx = lo_reg;
        if (cmd.probe)
        begin
            rd_idx = mid;
        end
        else if (cmd.shrd_up)
        begin
            rd_idx = idx_reg - 1'b1;
        end
        else if (cmd.shrd_dn)
        begin
            rd_idx = idx_reg + 1'b1;
        end
    end

    assign rd_en   = cmd.probe | cmd.hit_probe | cmd.shrd_up | cmd.shrd_dn;
    assign rd_addr = rd_idx[AW-1:0];
    assign wr_en   = cmd.shwr_up | cmd.shwr_dn | cmd.ins;
    assign wr_addr = cmd.ins ? lo_reg[AW-1:0] : idx_reg[AW-1:0];
    assign wr_data = cmd.ins ? key_reg : rd_data;

    sset_ram #(
        .WIDTH (KW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // payload and working state of the item in flight, and the result register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            key_reg  <= key[KW-1:0];
        end
        if (cmd.init_up)
        begin
            idx_reg <= count_reg;
        end
        else if (cmd.init_dn)
        begin
            idx_reg <= lo_reg;
        end
        else if (cmd.shwr_up)
        begin
            idx_reg <= idx_reg - 1'b1;
        end
        else if (cmd.shwr_dn)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (cmd.load)
        begin
            hit_reg  <= 1'b0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hit_check)
            begin
                hit_reg <= (rd_data == key_reg);
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
        end
        if (cmd.out_load)
        begin
            found_reg    <= hit_reg;
            position_reg <= lo_reg;
            total_reg    <= count_reg;
            status_reg   <= full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg        <= '0;
            hi_reg        <= '0;
            count_reg     <= '0;
            capacity_reg  <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                lo_reg <= '0;
                hi_reg <= count_reg;
            end
            else if (cmd.narrow)
            begin
                if (rd_data < key_reg)
                begin
                    lo_reg <= mid + 1'b1;
                end
                else
                begin
                    hi_reg <= mid;
                end
            end
            if (cmd.ins)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.del)
            begin
                count_reg <= count_reg - 1'b1;
            end
            if (cfg_valid)
            begin
                capacity_reg <= capacity;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign position    = position_reg;
    assign entry_total = total_reg;
    assign status      = status_reg;

    a_window: assert property (@(posedge clk) disable iff (!rst_n)
        lo_reg <= hi_reg)
        else $error("search window inverted");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ins: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> (count_reg < CW'(DEPTH)) && (lo_reg <= count_reg))
        else $error("insert outside held range");

    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while stalled");

endmodule

[design/sorted_set_binary_search.sv]
// Sorted key set: holds up to DEPTH distinct keys in ascending unsigned order.
// Input channel (in_valid/in_stall) carries one beat per operation: func
// (0 add, 1 remove, 2 or 3 find) and key; only the low 8*KEY_BYTES bits of key
// are kept. Output channel (out_valid/out_stall) returns one beat per input
// beat: found, position (index or insertion point), entry_total after the
// operation, and status (1 when an add is refused because the set is full).
// The capacity register is written through cfg_valid/cfg_ready; ready is
// always high. Write it only while no operation is in flight.
// From the accepting edge to out_valid: each binary-search probe reads the entry
// at mid, then narrows the window (up to ceil(log2(count+1)) probes, 7 at 64
// entries); the search closes, the entry at the insertion point is read and
// checked against the key when that point is below the count, and the operation
// is decided. Add and remove then move each entry by a read and a write through
// the key RAM and end with the key write or the count update before hand-off.
// One operation is worked on at a time; in_stall is high from the accepting
// edge until the hand-off, so the next beat is taken in the cycle after it. A
// stalled result is held in the output register while the next beat is accepted
// and run; that operation then waits at its end until the register frees up.
// Reset empties the set and sets capacity to 64; the key RAM needs no
// clearing since only entries below the count are ever read.
module sorted_set_binary_search #(
    parameter int DEPTH     = sset_pkg::DEPTH_DEF,
    parameter int KEY_BYTES = sset_pkg::KEY_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [sset_pkg::FUNC_W-1:0] func,
    input  logic [sset_pkg::KEY_W-1:0]  key,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [sset_pkg::CAP_W-1:0]  capacity,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        found,
    output logic [$clog2(DEPTH+1)-1:0]  position,
    output logic [$clog2(DEPTH+1)-1:0]  entry_total,
    output logic                        status
);
    import sset_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // capacity writes are taken straight into the register, so never hold off the writer
    assign cfg_ready = 1'b1;

    sset_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sset_dpath #(
        .DEPTH     (DEPTH),
        .KEY_BYTES (KEY_BYTES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .func        (func),
        .key         (key),
        .cfg_valid   (cfg_valid),
        .capacity    (capacity),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position),
        .entry_total (entry_total),
        .status      (status)
    );

endmodule
